// ===== hdl/ptdg_pkg.sv =====
// Shared constants, types and the seed table of the trial-division prime generator.
`default_nettype none

package ptdg_pkg;

    // Sizes of the prime table and of the value fields.
    localparam int VALUE_WIDTH = 32;
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_WIDTH  = $clog2(TABLE_DEPTH);
    localparam int INDEX_WIDTH = ADDR_WIDTH + 1;

    // A candidate may run two past the largest value, so it carries one extra bit.
    localparam int CAND_WIDTH  = VALUE_WIDTH + 1;

    // The divider retires one quotient bit per cycle over the whole candidate.
    localparam int DIV_STEPS   = CAND_WIDTH;
    localparam int STEP_WIDTH  = $clog2(DIV_STEPS + 1);

    localparam logic [INDEX_WIDTH-1:0] TABLE_DEPTH_IDX = INDEX_WIDTH'(TABLE_DEPTH);
    localparam logic [INDEX_WIDTH-1:0] SEED_COUNT      = INDEX_WIDTH'(3);
    localparam logic [CAND_WIDTH-1:0]  FIRST_ODD_CAND  = CAND_WIDTH'(7);
    localparam logic [VALUE_WIDTH-1:0] LIMIT_RESET     = VALUE_WIDTH'(100);

    // Status that the divider hands back to the sequencer.
    typedef struct packed {
        logic done;
        logic rem_zero;
        logic quot_small;
    } div_status_t;

    // The first three primes, given without any search.
    function automatic logic [VALUE_WIDTH-1:0] seed_prime(input logic [1:0] sel);
        logic [VALUE_WIDTH-1:0] result;
        begin
            case (sel)
                2'd0:    result = VALUE_WIDTH'(2);
                2'd1:    result = VALUE_WIDTH'(3);
                default: result = VALUE_WIDTH'(5);
            endcase
            return result;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ptdg_divider.sv =====
// Radix-2 restoring divider: one quotient bit per cycle, quotient shifted into the dividend register.
`default_nettype none

module ptdg_divider
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [ptdg_pkg::CAND_WIDTH-1:0]    dividend,
    input  wire logic [ptdg_pkg::VALUE_WIDTH-1:0]   divisor,
    output      ptdg_pkg::div_status_t              status
);
    import ptdg_pkg::*;

    logic [VALUE_WIDTH-1:0] rem_reg,  rem_next;
    logic [CAND_WIDTH-1:0]  dq_reg,   dq_next;
    logic [VALUE_WIDTH-1:0] dvs_reg,  dvs_next;
    logic [STEP_WIDTH-1:0]  cnt_reg,  cnt_next;
    logic                   busy_reg, busy_next;

    logic [CAND_WIDTH-1:0]  partial;
    logic [CAND_WIDTH:0]    diff;
    logic                   fits;

    // Bring down the next dividend bit and try the subtraction.
    assign partial = {rem_reg, dq_reg[CAND_WIDTH-1]};
    assign diff    = {1'b0, partial} - {2'b00, dvs_reg};
    assign fits    = ~diff[CAND_WIDTH];

    // Step sequencing: load on start, shift while counting down, stop when the count is spent.
    always_comb
    begin
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
            cnt_next  = STEP_WIDTH'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_next = fits ? diff[VALUE_WIDTH-1:0] : partial[VALUE_WIDTH-1:0];
                dq_next  = {dq_reg[CAND_WIDTH-2:0], fits};
                cnt_next = cnt_reg - STEP_WIDTH'(1);
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    // A quotient below the divisor means divisor squared exceeds the dividend.
    assign status.done       = busy_reg && (cnt_reg == '0);
    assign status.rem_zero   = (rem_reg == '0);
    assign status.quot_small = (dq_reg < {1'b0, dvs_reg});

endmodule

`default_nettype wire

// ===== hdl/ptdg_table.sv =====
// Prime table: one write port and one registered read port.
`default_nettype none

module ptdg_table
(
    input  wire logic                               clk,
    input  wire logic                               wr_en,
    input  wire logic [ptdg_pkg::ADDR_WIDTH-1:0]    wr_addr,
    input  wire logic [ptdg_pkg::VALUE_WIDTH-1:0]   wr_data,
    input  wire logic                               rd_en,
    input  wire logic [ptdg_pkg::ADDR_WIDTH-1:0]    rd_addr,
    output      logic [ptdg_pkg::VALUE_WIDTH-1:0]   rd_data
);
    import ptdg_pkg::*;

    logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: data is registered and comes the cycle after an enabled address.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/prime_trial_division_generator.sv =====
// Top level: request sequencer, candidate search and result register of the prime generator.
//
//   Channel   Handshake                 Payload
//   request   req_valid / req_stall     restart
//   result    res_valid / res_stall     prime_value, prime_index, limit_reached, table_full
//   config    cfg_valid / cfg_ready     cfg_data (upper_limit, reset 100)
//
// Restart, seed and table-full requests answer in the cycle after acceptance.
// A search checks each candidate against the limit, then per trial divisor reads the table,
// loads the divider and waits for the bit-serial divider, so the time is data dependent.
// Reset leaves the table contents undefined; only entries below the stored count are read.
// One request is in work at a time; a result waiting on res_stall holds off the next request.
`default_nettype none

module prime_trial_division_generator
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output      logic                               req_stall,
    input  wire logic                               restart,
    output      logic                               res_valid,
    input  wire logic                               res_stall,
    output      logic [ptdg_pkg::VALUE_WIDTH-1:0]   prime_value,
    output      logic [ptdg_pkg::INDEX_WIDTH-1:0]   prime_index,
    output      logic                               limit_reached,
    output      logic                               table_full,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [ptdg_pkg::VALUE_WIDTH-1:0]   cfg_data
);
    import ptdg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [INDEX_WIDTH-1:0] count_reg, count_next;
    logic [CAND_WIDTH-1:0]  cand_reg,  cand_next;
    logic [INDEX_WIDTH-1:0] idx_reg,   idx_next;
    logic [VALUE_WIDTH-1:0] limit_reg, limit_next;

    logic                   res_valid_reg, res_valid_next;
    logic [VALUE_WIDTH-1:0] value_reg,     value_next;
    logic [INDEX_WIDTH-1:0] index_reg,     index_next;
    logic                   lim_reg,       lim_next;
    logic                   full_reg,      full_next;

    logic                   accept;
    logic                   load_res;
    logic                   wr_en;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   div_start;
    div_status_t            div_status;
    logic [INDEX_WIDTH-1:0] idx_inc;

    // Handshakes.
    assign req_stall = (state_reg != S_IDLE) || (res_valid_reg && res_stall);
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign idx_inc   = idx_reg + INDEX_WIDTH'(1);

    // Limit register.
    assign limit_next = (cfg_valid && cfg_ready) ? cfg_data : limit_reg;

    // Request sequencer and candidate search.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cand_next  = cand_reg;
        idx_next   = idx_reg;
        load_res   = 1'b0;
        value_next = value_reg;
        index_next = index_reg;
        lim_next   = lim_reg;
        full_next  = full_reg;
        wr_en      = 1'b0;
        wr_data    = cand_reg[VALUE_WIDTH-1:0];
        rd_en      = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        count_next = '0;
                        cand_next  = FIRST_ODD_CAND;
                        load_res   = 1'b1;
                        value_next = '0;
                        index_next = '0;
                        lim_next   = 1'b0;
                        full_next  = 1'b0;
                    end
                    else if (count_reg == TABLE_DEPTH_IDX)
                    begin
                        load_res   = 1'b1;
                        value_next = '0;
                        index_next = count_reg;
                        lim_next   = 1'b0;
                        full_next  = 1'b1;
                    end
                    else if (count_reg < SEED_COUNT)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = seed_prime(count_reg[1:0]);
                        count_next = count_reg + INDEX_WIDTH'(1);
                        load_res   = 1'b1;
                        value_next = seed_prime(count_reg[1:0]);
                        index_next = count_reg + INDEX_WIDTH'(1);
                        lim_next   = 1'b0;
                        full_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (cand_reg > {1'b0, limit_reg})
                begin
                    load_res   = 1'b1;
                    value_next = '0;
                    index_next = count_reg;
                    lim_next   = 1'b1;
                    full_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = INDEX_WIDTH'(1);
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    if (!div_status.quot_small && div_status.rem_zero)
                    begin
                        // A divisor found: move on to the next odd candidate.
                        cand_next  = cand_reg + CAND_WIDTH'(2);
                        state_next = S_CHECK;
                    end
                    else if (!div_status.quot_small && (idx_inc != count_reg))
                    begin
                        idx_next   = idx_inc;
                        state_next = S_READ;
                    end
                    else
                    begin
                        // No divisor up to the square root, or none left: a prime.
                        wr_en      = 1'b1;
                        count_next = count_reg + INDEX_WIDTH'(1);
                        cand_next  = cand_reg + CAND_WIDTH'(2);
                        load_res   = 1'b1;
                        value_next = cand_reg[VALUE_WIDTH-1:0];
                        index_next = count_reg + INDEX_WIDTH'(1);
                        lim_next   = 1'b0;
                        full_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register: filled only when its slot is free, emptied when taken.
    assign res_valid_next = load_res || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cand_reg      <= FIRST_ODD_CAND;
            idx_reg       <= '0;
            limit_reg     <= LIMIT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cand_reg      <= cand_next;
            idx_reg       <= idx_next;
            limit_reg     <= limit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        index_reg <= index_next;
        lim_reg   <= lim_next;
        full_reg  <= full_next;
    end

    assign res_valid     = res_valid_reg;
    assign prime_value   = value_reg;
    assign prime_index   = index_reg;
    assign limit_reached = lim_reg;
    assign table_full    = full_reg;

    // Prime table, appended at the stored count.
    ptdg_table u_table
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_WIDTH-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[ADDR_WIDTH-1:0]),
        .rd_data (rd_data)
    );

    // Trial divider.
    ptdg_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cand_reg),
        .divisor  (rd_data),
        .status   (div_status)
    );

endmodule

`default_nettype wire
